// File: hw/rtl/hrlp_pkg.sv
// Shared types, constants and helpers for the HTTP request line parser.
// No dependencies; used by hrlp_step and http_request_line_parser_core.
`timescale 1ns / 1ps

package hrlp_pkg;

    localparam int METHOD_MAX  = 8;
    localparam int PATH_MAX    = 512;
    localparam int QUERY_MAX   = 512;
    localparam int VERSION_MAX = 16;

    localparam int CNT_W    = 10;
    localparam int QLEN_MIN = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_PATH    = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_VERSION = 3'd4;

    localparam logic [2:0] STAT_PROGRESS  = 3'd0;
    localparam logic [2:0] STAT_ACCEPTED  = 3'd1;
    localparam logic [2:0] STAT_BAD_METH  = 3'd2;
    localparam logic [2:0] STAT_BAD_QUERY = 3'd3;
    localparam logic [2:0] STAT_NO_LF     = 3'd4;

    typedef enum logic [5:0] {
        PH_DONE    = 6'b000001,
        PH_METHOD  = 6'b000010,
        PH_PATH    = 6'b000100,
        PH_QUERY   = 6'b001000,
        PH_VERSION = 6'b010000,
        PH_LF      = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [CNT_W-1:0]   field_count;
        logic [CNT_W-1:0]   query_length;
        logic               query_zero_seen;
        logic               query_chars_ok;
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] field_kind;
        logic [7:0] echo_byte;
        logic [2:0] line_status;
        logic       line_done;
    } out_item_t;

    function automatic logic query_byte_allowed(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
               b == CH_UNDER || b == CH_AMP || b == CH_EQ;
    endfunction

endpackage

// File: hw/rtl/hrlp_step.sv
// Per-byte parse step: next parser state and the result for one byte.
// Pure combinational logic; depends on hrlp_pkg.
`timescale 1ns / 1ps

module hrlp_step (
    input  hrlp_pkg::parse_state_t cur_state,
    input  hrlp_pkg::in_item_t     item,
    output hrlp_pkg::parse_state_t next_state,
    output hrlp_pkg::out_item_t    result
);

    localparam int CW = hrlp_pkg::CNT_W + 1;

    hrlp_pkg::parse_state_t st;
    logic [CW-1:0]          cnt_inc;
    logic [7:0]             b;
    logic [2:0]             kind;
    logic [2:0]             status;
    logic                   stored;
    logic                   q_good;
    logic                   q_chars_new;
    logic [hrlp_pkg::CNT_W-1:0] q_len_new;

    always_comb begin
        b      = item.data_byte;
        st     = cur_state;
        kind   = hrlp_pkg::KIND_NONE;
        status = hrlp_pkg::STAT_PROGRESS;
        stored = 1'b0;

        if (item.first_byte) begin
            st.phase           = hrlp_pkg::PH_METHOD;
            st.field_count     = '0;
            st.query_length    = '0;
            st.query_zero_seen = 1'b0;
            st.query_chars_ok  = 1'b1;
        end

        cnt_inc     = {1'b0, st.field_count} + CW'(1);
        q_len_new   = st.query_length;
        q_chars_new = st.query_chars_ok;
        if (!st.query_zero_seen && b != hrlp_pkg::CH_NUL) begin
            if (st.query_length != {hrlp_pkg::CNT_W{1'b1}}) begin
                q_len_new = st.query_length + hrlp_pkg::CNT_W'(1);
            end
            if (!hrlp_pkg::query_byte_allowed(b)) begin
                q_chars_new = 1'b0;
            end
        end
        q_good = 1'b0;

        case (st.phase)
            hrlp_pkg::PH_METHOD: begin
                if (b == hrlp_pkg::CH_SPACE) begin
                    st.phase       = hrlp_pkg::PH_PATH;
                    st.field_count = '0;
                end else if (!(b inside {[8'h41:8'h5A]})) begin
                    kind     = hrlp_pkg::KIND_METHOD;
                    stored   = 1'b1;
                    status   = hrlp_pkg::STAT_BAD_METH;
                    st.phase = hrlp_pkg::PH_DONE;
                end else begin
                    kind           = hrlp_pkg::KIND_METHOD;
                    stored         = 1'b1;
                    st.field_count = cnt_inc[hrlp_pkg::CNT_W-1:0];
                    if (cnt_inc >= CW'(hrlp_pkg::METHOD_MAX)) begin
                        st.phase       = hrlp_pkg::PH_PATH;
                        st.field_count = '0;
                    end
                end
            end
            hrlp_pkg::PH_PATH: begin
                if (b == hrlp_pkg::CH_SPACE) begin
                    st.phase       = hrlp_pkg::PH_VERSION;
                    st.field_count = '0;
                end else if (b == hrlp_pkg::CH_QMARK) begin
                    st.phase       = hrlp_pkg::PH_QUERY;
                    st.field_count = '0;
                end else begin
                    kind           = hrlp_pkg::KIND_PATH;
                    stored         = 1'b1;
                    st.field_count = cnt_inc[hrlp_pkg::CNT_W-1:0];
                    if (cnt_inc >= CW'(hrlp_pkg::PATH_MAX)) begin
                        st.phase       = hrlp_pkg::PH_VERSION;
                        st.field_count = '0;
                    end
                end
            end
            hrlp_pkg::PH_QUERY: begin
                if (b == hrlp_pkg::CH_SPACE) begin
                    q_good = (st.query_length >= hrlp_pkg::CNT_W'(hrlp_pkg::QLEN_MIN)) &&
                             st.query_chars_ok;
                    st.field_count = '0;
                    st.phase  = q_good ? hrlp_pkg::PH_VERSION : hrlp_pkg::PH_DONE;
                    status    = q_good ? hrlp_pkg::STAT_PROGRESS : hrlp_pkg::STAT_BAD_QUERY;
                end else begin
                    kind   = hrlp_pkg::KIND_QUERY;
                    stored = 1'b1;
                    if (!st.query_zero_seen && b == hrlp_pkg::CH_NUL) begin
                        st.query_zero_seen = 1'b1;
                    end
                    st.query_length   = q_len_new;
                    st.query_chars_ok = q_chars_new;
                    st.field_count    = cnt_inc[hrlp_pkg::CNT_W-1:0];
                    if (cnt_inc >= CW'(hrlp_pkg::QUERY_MAX)) begin
                        q_good = (q_len_new >= hrlp_pkg::CNT_W'(hrlp_pkg::QLEN_MIN)) &&
                                 q_chars_new;
                        st.field_count = '0;
                        st.phase  = q_good ? hrlp_pkg::PH_VERSION : hrlp_pkg::PH_DONE;
                        status    = q_good ? hrlp_pkg::STAT_PROGRESS
                                           : hrlp_pkg::STAT_BAD_QUERY;
                    end
                end
            end
            hrlp_pkg::PH_VERSION: begin
                if (b == hrlp_pkg::CH_CR) begin
                    st.phase       = hrlp_pkg::PH_LF;
                    st.field_count = '0;
                end else begin
                    kind           = hrlp_pkg::KIND_VERSION;
                    stored         = 1'b1;
                    st.field_count = cnt_inc[hrlp_pkg::CNT_W-1:0];
                    if (cnt_inc >= CW'(hrlp_pkg::VERSION_MAX)) begin
                        st.phase       = hrlp_pkg::PH_LF;
                        st.field_count = '0;
                    end
                end
            end
            hrlp_pkg::PH_LF: begin
                status   = (b == hrlp_pkg::CH_LF) ? hrlp_pkg::STAT_ACCEPTED
                                                  : hrlp_pkg::STAT_NO_LF;
                st.phase = hrlp_pkg::PH_DONE;
            end
            default: begin
                st.phase = hrlp_pkg::PH_DONE;
            end
        endcase

        next_state         = st;
        result.field_kind  = kind;
        result.echo_byte   = stored ? b : 8'h00;
        result.line_status = status;
        result.line_done   = (status != hrlp_pkg::STAT_PROGRESS);
    end

endmodule

// File: hw/rtl/http_request_line_parser_core.sv
// HTTP request line parser: each byte is held in the input register, its result in the result register (two stages).
// Throughput one byte per cycle unless the output stalls (m_ready low); set by the single parse step between the
// input register and the result register, which also updates the parser state.
// Reset (aresetn low, synchronous): both registers empty, parser waiting for a
// first byte. Depends on hrlp_pkg and hrlp_step.
`timescale 1ns / 1ps

module http_request_line_parser_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrlp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrlp_pkg::out_item_t m_data
);

    logic                   in_valid_reg;
    hrlp_pkg::in_item_t     in_data_reg;
    logic                   out_valid_reg;
    hrlp_pkg::out_item_t    out_data_reg;
    hrlp_pkg::parse_state_t state_reg;
    hrlp_pkg::parse_state_t state_next;
    hrlp_pkg::out_item_t    step_out;
    logic                   advance;

    hrlp_step u_step (
        .cur_state  (state_reg),
        .item       (in_data_reg),
        .next_state (state_next),
        .result     (step_out)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.phase           <= hrlp_pkg::PH_DONE;
            state_reg.field_count     <= '0;
            state_reg.query_length    <= '0;
            state_reg.query_zero_seen <= 1'b0;
            state_reg.query_chars_ok  <= 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_out;
        end
    end

    a_done_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.line_done == (m_data.line_status != hrlp_pkg::STAT_PROGRESS)))
        else $error("line_done disagrees with line_status");

    a_no_echo_when_untagged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.field_kind == hrlp_pkg::KIND_NONE |-> m_data.echo_byte == 8'h00)
        else $error("echo byte set on untagged result");

    a_done_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_out.line_done |=> state_reg.phase == hrlp_pkg::PH_DONE)
        else $error("parser not idle after line end");

    a_stalled_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a stalled item");

    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without a transfer");

endmodule
